// File: hw/rtl/mcts_pkg.sv
// ----------------------------------------------------------------------------
// mcts_pkg
// Shared constants and types of the MIPS call target scanner: table sizing,
// instruction decode masks and the structs passed between its modules.
// ----------------------------------------------------------------------------
package mcts_pkg;

	localparam int unsigned TABLE_DEPTH = 256;
	localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
	localparam int unsigned CNT_W       = IDX_W + 1;

	localparam logic [31:0] LUI_MASK    = 32'hFFE0_0000;
	localparam logic [31:0] LUI_CODE    = 32'h3C00_0000;
	localparam logic [31:0] JR_MASK     = 32'hFC1F_FFFF;
	localparam logic [31:0] JR_CODE     = 32'h0000_0008;
	localparam logic [31:0] REGION_MASK = 32'hF000_0000;
	localparam logic [5:0]  OP_JAL      = 6'd3;
	localparam logic [5:0]  OP_ADDIU    = 6'd9;

	// Up to two targets found on one instruction word, in report order.
	typedef struct packed {
		logic [1:0]  cnt;
		logic [31:0] t0;
		logic [31:0] t1;
	} cand_t;

	// Lookup request to the table search unit.
	typedef struct packed {
		logic        start;
		logic [31:0] target;
	} srch_req_t;

	// Lookup answer; is_new and full hold until the next answer.
	typedef struct packed {
		logic done;
		logic is_new;
		logic full;
	} srch_rsp_t;

endpackage

// File: hw/rtl/mcts_if.sv
// ----------------------------------------------------------------------------
// mcts_if
// Valid/ready channels of the scanner: instruction words in, targets out.
// ----------------------------------------------------------------------------
interface mcts_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] instr_word;
	logic        first_word;

	modport source (output valid, output instr_word, output first_word, input ready);
	modport sink   (input valid, input instr_word, input first_word, output ready);
endinterface

interface mcts_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] target_address;
	logic        is_new;
	logic        table_full;
	logic        last_result;

	modport source (output valid, output target_address, output is_new,
		output table_full, output last_result, input ready);
	modport sink   (input valid, input target_address, input is_new,
		input table_full, input last_result, output ready);
endinterface

// File: hw/rtl/mips_call_target_scanner.sv
// ----------------------------------------------------------------------------
// mips_call_target_scanner
// Scans MIPS instruction words for function entry addresses and reports each
// one with a deduplication verdict.
// ----------------------------------------------------------------------------
// The scanner takes one instruction word per request and reports zero, one or
// two targets per word: the base address when the word is flagged as the
// first of an image, the destination of a JAL, and the destination of the
// long-jump idiom LUI r / [other word] / ADDIU r / JR r, with or without the
// other word, reported on the JR word. Each target is looked up in a table of
// TABLE_DEPTH entries that only reset clears; a new target is stored while
// there is room. The lookup is a linear scan by one comparator over a RAM
// with registered read, one entry per cycle, so its cost grows with the
// number of stored targets; a lookup ends early when the target is found.
// Each result also waits for the sink to take the previous result. The input
// is not ready while a word is being processed; the last result of a word
// may still wait in the output register while the next word is accepted.
// The table needs no clearing pass after reset, because only entries below
// the fill count are ever read. The base address is written through
// cfg_wr_en and cfg_wr_data and should only be changed while the scanner is
// idle.
// ----------------------------------------------------------------------------
module mips_call_target_scanner import mcts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	mcts_in_if.sink     item_in,
	mcts_out_if.source  result_out
);

	// Top-level sequencer: take a word, walk its targets through the search
	// unit one at a time, and hand each verdict to the output register.
	typedef enum logic [1:0] {
		T_IDLE,
		T_LOAD,
		T_SRCH,
		T_PUSH
	} state_t;

	state_t      state_q;
	logic        idx_q;
	logic        out_valid_q;
	logic [31:0] out_tgt_q;
	logic        out_new_q;
	logic        out_full_q;
	logic        out_last_q;

	logic        accept;
	logic        out_free;
	logic [31:0] cur_tgt;
	logic        cur_last;
	cand_t       cand;
	srch_req_t   req;
	srch_rsp_t   rsp;

	assign accept   = item_in.valid && item_in.ready;
	assign out_free = !out_valid_q || result_out.ready;

	// The second slot is only used when the word produced two targets.
	assign cur_tgt  = idx_q ? cand.t1 : cand.t0;
	assign cur_last = idx_q || (cand.cnt == 2'd1);

	assign req.start  = (state_q == T_LOAD) && (cand.cnt != 2'd0);
	assign req.target = cur_tgt;

	mcts_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.accept      (accept),
		.instr_word  (item_in.instr_word),
		.first_word  (item_in.first_word),
		.cand        (cand)
	);

	mcts_search u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			idx_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_tgt_q   <= '0;
			out_new_q   <= 1'b0;
			out_full_q  <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_valid_q && result_out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					idx_q <= 1'b0;
					if (accept) begin
						state_q <= T_LOAD;
					end
				end
				T_LOAD: begin
					// The candidate list was registered on the accepting edge.
					if (cand.cnt == 2'd0) begin
						state_q <= T_IDLE;
					end else begin
						state_q <= T_SRCH;
					end
				end
				T_SRCH: begin
					if (rsp.done) begin
						state_q <= T_PUSH;
					end
				end
				T_PUSH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_tgt_q   <= cur_tgt;
						out_new_q   <= rsp.is_new;
						out_full_q  <= rsp.full;
						out_last_q  <= cur_last;
						if (cur_last) begin
							state_q <= T_IDLE;
						end else begin
							idx_q   <= 1'b1;
							state_q <= T_LOAD;
						end
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign item_in.ready             = state_q == T_IDLE;
	assign result_out.valid          = out_valid_q;
	assign result_out.target_address = out_tgt_q;
	assign result_out.is_new         = out_new_q;
	assign result_out.table_full     = out_full_q;
	assign result_out.last_result    = out_last_q;

endmodule

// File: hw/rtl/mcts_ram.sv
// ----------------------------------------------------------------------------
// mcts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mcts_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hw/rtl/mcts_window.sv
// ----------------------------------------------------------------------------
// mcts_window
// Word window and address tracker. On each accepted word it registers the
// targets that the word produces and then shifts the word into the window.
// ----------------------------------------------------------------------------
module mcts_window import mcts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        accept,
	input  logic [31:0] instr_word,
	input  logic        first_word,
	output cand_t       cand
);

	logic [31:0] win_q [3];
	logic [1:0]  fill_q;
	logic [31:0] addr_q;
	logic [31:0] base_q;
	cand_t       cand_q;

	logic [31:0] addr_eff;
	logic        jal;
	logic [31:0] jal_t;
	logic [4:0]  r4;
	logic [4:0]  r3;
	logic        lj4;
	logic        lj3;
	logic [31:0] lt4;
	logic [31:0] lt3;
	cand_t       cand_d;

	function automatic logic is_lui(input logic [31:0] w);
		return (w & LUI_MASK) == LUI_CODE;
	endfunction

	function automatic logic is_addiu_on(input logic [31:0] w, input logic [4:0] r);
		return (w[31:26] == OP_ADDIU) && (w[25:21] == r);
	endfunction

	function automatic logic is_jr_on(input logic [31:0] w, input logic [4:0] r);
		return ((w & JR_MASK) == JR_CODE) && (w[25:21] == r);
	endfunction

	always_comb begin
		addr_eff = first_word ? base_q : addr_q;
		jal      = instr_word[31:26] == OP_JAL;
		jal_t    = (addr_eff & REGION_MASK) + {4'b0000, instr_word[25:0], 2'b00};
		r4       = win_q[2][20:16];
		r3       = win_q[1][20:16];
		// A flagged first word empties the window, so no pattern can close on it.
		lj4 = !first_word && (fill_q == 2'd3) && is_lui(win_q[2])
			&& !is_addiu_on(win_q[1], r4) && is_addiu_on(win_q[0], r4)
			&& is_jr_on(instr_word, r4);
		lj3 = !first_word && (fill_q >= 2'd2) && is_lui(win_q[1])
			&& is_addiu_on(win_q[0], r3) && is_jr_on(instr_word, r3);
		lt4 = {win_q[2][15:0], win_q[0][15:0]};
		lt3 = {win_q[1][15:0], win_q[0][15:0]};

		cand_d.cnt = 2'd0;
		cand_d.t0  = '0;
		cand_d.t1  = '0;
		if (first_word) begin
			cand_d.t0  = base_q;
			cand_d.cnt = 2'd1;
		end
		if (jal) begin
			if (first_word) begin
				cand_d.t1 = jal_t;
			end else begin
				cand_d.t0 = jal_t;
			end
			cand_d.cnt = cand_d.cnt + 2'd1;
		end else begin
			if (lj4) begin
				cand_d.t0  = lt4;
				cand_d.cnt = 2'd1;
			end
			if (lj3) begin
				if (lj4) begin
					cand_d.t1 = lt3;
				end else begin
					cand_d.t0 = lt3;
				end
				cand_d.cnt = cand_d.cnt + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q[0] <= '0;
			win_q[1] <= '0;
			win_q[2] <= '0;
			fill_q   <= 2'd0;
			addr_q   <= '0;
			base_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				base_q <= cfg_wr_data;
			end
			if (accept) begin
				win_q[0] <= instr_word;
				win_q[1] <= first_word ? 32'd0 : win_q[0];
				win_q[2] <= first_word ? 32'd0 : win_q[1];
				if (first_word) begin
					fill_q <= 2'd1;
				end else if (fill_q != 2'd3) begin
					fill_q <= fill_q + 2'd1;
				end
				addr_q <= addr_eff + 32'd4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cand_q <= cand_d;
		end
	end

	assign cand = cand_q;

endmodule

// File: hw/rtl/mcts_search.sv
// ----------------------------------------------------------------------------
// mcts_search
// Deduplication table: a RAM of stored targets scanned one entry per cycle
// by a single comparator, with an insert at the fill count on a miss while not full.
// ----------------------------------------------------------------------------
module mcts_search import mcts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  srch_req_t req,
	output srch_rsp_t rsp
);

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	state_t          state_q;
	logic [31:0]     tgt_q;
	logic            full_q;
	logic [CNT_W-1:0] issue_q;
	logic            pend_s1;
	logic [CNT_W-1:0] cnt_q;
	srch_rsp_t       rsp_q;

	logic            issue_go;
	logic            hit;
	logic            miss_end;
	logic            wr_en;
	logic [31:0]     rd_data;

	always_comb begin
		issue_go = (state_q == S_SCAN) && (issue_q != cnt_q);
		hit      = (state_q == S_SCAN) && pend_s1 && (rd_data == tgt_q);
		miss_end = (state_q == S_SCAN) && !pend_s1 && (issue_q == cnt_q);
		wr_en    = miss_end && !full_q;
	end

	mcts_ram #(
		.WIDTH (32),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[IDX_W-1:0]),
		.wr_data (tgt_q),
		.rd_en   (issue_go),
		.rd_addr (issue_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tgt_q   <= '0;
			full_q  <= 1'b0;
			issue_q <= '0;
			pend_s1 <= 1'b0;
			cnt_q   <= '0;
			rsp_q   <= '0;
		end else begin
			rsp_q.done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.start) begin
						tgt_q   <= req.target;
						full_q  <= cnt_q == CNT_W'(TABLE_DEPTH);
						issue_q <= '0;
						pend_s1 <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					pend_s1 <= issue_go;
					if (issue_go) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (hit) begin
						rsp_q.done   <= 1'b1;
						rsp_q.is_new <= 1'b0;
						rsp_q.full   <= full_q;
						state_q      <= S_IDLE;
					end else if (miss_end) begin
						rsp_q.done   <= 1'b1;
						rsp_q.is_new <= 1'b1;
						rsp_q.full   <= full_q;
						if (!full_q) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp = rsp_q;

endmodule
